[rtl/core/plars_pkg.sv]
// ----------------------------------------------------------------------------
// plars_pkg
// Shared constants and types for the polyline arc-length resampler.
// ----------------------------------------------------------------------------
package plars_pkg;

  localparam int unsigned MaxPointsDflt  = 256;
  localparam int unsigned MaxSamplesDflt = 64;

  localparam int unsigned CoordW = 18;
  localparam int unsigned LenW   = 28;
  localparam int unsigned FracW  = 17;
  localparam int unsigned CntW   = 7;

  localparam logic [LenW-1:0]  LenMax  = '1;
  localparam logic [FracW-1:0] FracOne = 17'h10000;

  // configuration register indexes
  localparam logic [1:0] RegCount = 2'd0;
  localparam logic [1:0] RegStart = 2'd1;
  localparam logic [1:0] RegEnd   = 2'd2;

  // divider request and reply
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

[rtl/core/plars_div.sv]
// ----------------------------------------------------------------------------
// plars_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plars_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plars_pkg::div_req_t req_i,
  output plars_pkg::div_rsp_t rsp_o
);

  logic [63:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[63]} - {1'b0, den_q};
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[rtl/core/polyline_arc_length_resampler_core.sv]
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler_core
// Loads polyline points, accumulates arc length, then emits resampled points.
// Loading a point runs a previous point read, three squarings, a 20-step
// bit-pair sqrt loop and a store write; a curve's first point goes straight
// to the store write. A last point then runs a setup and a start product,
// and per sample the span and step products, a step division (none for a
// count of one), a segment walk, reads of both segment end points and three
// interpolation divisions (none on a zero-length segment); results wait in
// an output register, and after the final result the block is ready again.
// Throughput is set by the shared serial divider, sqrt and back-pressure.
// Reset is asynchronous active low; point stores are not cleared.
// ----------------------------------------------------------------------------
module polyline_arc_length_resampler_core #(
  parameter int unsigned MaxPoints  = plars_pkg::MaxPointsDflt,
  parameter int unsigned MaxSamples = plars_pkg::MaxSamplesDflt
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [plars_pkg::CoordW-1:0]   pos_x_i,
  input  logic signed [plars_pkg::CoordW-1:0]   pos_y_i,
  input  logic signed [plars_pkg::CoordW-1:0]   pos_z_i,
  input  logic                                  last_point_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [plars_pkg::CoordW-1:0]   out_x_o,
  output logic signed [plars_pkg::CoordW-1:0]   out_y_o,
  output logic signed [plars_pkg::CoordW-1:0]   out_z_o,
  output logic                                  last_sample_o,
  output logic                                  empty_res_o,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [plars_pkg::FracW-1:0]           cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned NW    = $clog2(MaxPoints + 1);
  localparam int unsigned CW    = plars_pkg::CoordW;
  localparam int unsigned LW    = plars_pkg::LenW;
  localparam int unsigned FW    = plars_pkg::FracW;
  localparam int unsigned KW    = plars_pkg::CntW;

  // sequencer states
  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StRdPrev = 5'd1;
  localparam logic [4:0] StSqX    = 5'd2;
  localparam logic [4:0] StSqY    = 5'd3;
  localparam logic [4:0] StSqZ    = 5'd4;
  localparam logic [4:0] StSqrt   = 5'd5;
  localparam logic [4:0] StWrite  = 5'd6;
  localparam logic [4:0] StSetup  = 5'd7;
  localparam logic [4:0] StS0Mul  = 5'd8;
  localparam logic [4:0] StSpan   = 5'd9;
  localparam logic [4:0] StStep   = 5'd10;
  localparam logic [4:0] StStepW  = 5'd11;
  localparam logic [4:0] StWalkRd = 5'd12;
  localparam logic [4:0] StWalk   = 5'd13;
  localparam logic [4:0] StPtRd   = 5'd14;
  localparam logic [4:0] StPtA    = 5'd15;
  localparam logic [4:0] StPtB    = 5'd16;
  localparam logic [4:0] StLerp   = 5'd17;
  localparam logic [4:0] StLerpW  = 5'd18;
  localparam logic [4:0] StEmit   = 5'd19;
  localparam logic [4:0] StEmpty  = 5'd20;
  localparam logic [4:0] StOut    = 5'd21;

  // Point and length stores, one write port, registered reads
  logic [CW-1:0] mem_x [MaxPoints];
  logic [CW-1:0] mem_y [MaxPoints];
  logic [CW-1:0] mem_z [MaxPoints];
  logic [LW-1:0] mem_c [MaxPoints];
  logic [AddrW-1:0] rd_addr;
  logic [CW-1:0] rd_x_q, rd_y_q, rd_z_q;
  logic [LW-1:0] rd_c_q;
  logic          mem_we;

  logic [4:0]    state_q, state_d;
  logic [KW-1:0] count_q;
  logic [FW-1:0] rstart_q, rend_q;
  logic [NW-1:0] n_q;
  logic [LW-1:0] total_q;
  logic [CW-1:0] px_q, py_q, pz_q;
  logic          plast_q;
  logic [39:0]   sq_q;         // sum of squares
  logic [39:0]   rad_q;        // sqrt remainder
  logic [20:0]   root_q;
  logic [4:0]    it_q;         // sqrt iteration / step counter
  logic [LW-1:0] s0_q, p_q, base_q, den_q, num_q;
  logic [63:0]   span_q;
  logic [KW-1:0] cnt_q, si_q;
  logic [AddrW-1:0] j_q;
  logic [1:0]    ax_q;         // coordinate lane under interpolation
  logic signed [CW-1:0] a_q [3];
  logic signed [CW-1:0] b_q [3];
  logic signed [CW-1:0] res_q [3];
  logic signed [47:0] prod_q;  // signed (b-a)*num
  logic          neg_q;
  logic          ovalid_q, olast_q, oempty_q;
  logic signed [CW-1:0] ox_q, oy_q, oz_q;
  logic          out_load;     // output register takes a new result

  plars_pkg::div_req_t dreq;
  plars_pkg::div_rsp_t drsp;

  plars_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // Shared multiplier, one per cycle
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [CW:0] diff;
  logic [LW:0]        cum_sum;
  logic [KW-1:0]      cnt_clamp;
  logic [FW-1:0]      rs_c, re_c, rs_s, re_s;
  logic [AddrW-1:0]   wr_addr;
  logic [AddrW-1:0]   prev_addr;

  always_comb begin
    rs_c = (rstart_q > plars_pkg::FracOne) ? plars_pkg::FracOne : rstart_q;
    re_c = (rend_q > plars_pkg::FracOne) ? plars_pkg::FracOne : rend_q;
    rs_s = (rs_c > re_c) ? re_c : rs_c;
    re_s = (rs_c > re_c) ? rs_c : re_c;
    cnt_clamp = (count_q > KW'(MaxSamples)) ? KW'(MaxSamples) : count_q;
  end

  assign wr_addr    = n_q[AddrW-1:0];
  assign prev_addr  = AddrW'(n_q - NW'(1));
  assign in_ready_o = (state_q == StIdle);
  assign out_load   = (state_q == StEmit || state_q == StEmpty) &&
                      (!ovalid_q || out_ready_i);

  // datapath selection
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    diff    = '0;
    dreq    = '0;
    rd_addr = j_q;
    cum_sum = '0;
    mem_we  = 1'b0;
    unique case (state_q)
      StSqX: begin
        diff  = {px_q[CW-1], px_q} - {rd_x_q[CW-1], rd_x_q};
        mul_a = 35'(diff);
        mul_b = 35'(diff);
      end
      StSqY: begin
        diff  = {py_q[CW-1], py_q} - {rd_y_q[CW-1], rd_y_q};
        mul_a = 35'(diff);
        mul_b = 35'(diff);
      end
      StSqZ: begin
        diff  = {pz_q[CW-1], pz_q} - {rd_z_q[CW-1], rd_z_q};
        mul_a = 35'(diff);
        mul_b = 35'(diff);
      end
      StWrite: begin
        mem_we  = (n_q < NW'(MaxPoints));
        cum_sum = {1'b0, rd_c_q} + (LW+1)'(root_q);
      end
      StS0Mul: begin
        mul_a = 35'({1'b0, rs_s});
        mul_b = 35'({1'b0, total_q});
      end
      // (end - start) * i, then times the length
      StSpan: begin
        mul_a = 35'({1'b0, re_s - rs_s});
        mul_b = 35'({1'b0, si_q});
      end
      StStep: begin
        mul_a = 35'({1'b0, span_q[33:0]});
        mul_b = 35'({1'b0, total_q});
      end
      StWalkRd: rd_addr = AddrW'(j_q + AddrW'(1));
      StWalk:   rd_addr = AddrW'(j_q + AddrW'(1));
      StPtRd:   rd_addr = j_q;
      StPtA:    rd_addr = AddrW'(j_q + AddrW'(1));
      StLerp: begin
        diff  = {b_q[ax_q][CW-1], b_q[ax_q]} - {a_q[ax_q][CW-1], a_q[ax_q]};
        mul_a = 35'(diff);
        mul_b = 35'({1'b0, num_q});
      end
      default: ;
    endcase
    // previous point and its length stay on the read port while loading
    if (state_q == StRdPrev || state_q == StSqX || state_q == StSqY ||
        state_q == StSqZ || state_q == StSqrt || state_q == StWrite) begin
      rd_addr = prev_addr;
    end
    // division requests are issued from registered operands
    if (state_q == StStepW && it_q == 5'd0) begin
      dreq.start = 1'b1;
      dreq.num   = span_q;
      dreq.den   = 64'(cnt_q - KW'(1)) << 16;
    end
    if (state_q == StLerpW && it_q == 5'd0) begin
      dreq.start = 1'b1;
      dreq.num   = neg_q ? 64'(-prod_q) : 64'(prod_q);
      dreq.den   = 64'(den_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[wr_addr] <= px_q;
      mem_y[wr_addr] <= py_q;
      mem_z[wr_addr] <= pz_q;
      mem_c[wr_addr] <= (n_q == '0) ? '0 :
                        (cum_sum[LW] ? plars_pkg::LenMax : cum_sum[LW-1:0]);
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
    rd_z_q <= mem_z[rd_addr];
    rd_c_q <= mem_c[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= KW'(5);
      rstart_q <= '0;
      rend_q   <= plars_pkg::FracOne;
      n_q      <= '0;
      total_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          plars_pkg::RegCount: count_q  <= cfg_data_i[KW-1:0];
          plars_pkg::RegStart: rstart_q <= cfg_data_i;
          plars_pkg::RegEnd:   rend_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (ovalid_q && out_ready_i && !out_load) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_valid_i) begin
          px_q <= pos_x_i; py_q <= pos_y_i; pz_q <= pos_z_i;
          plast_q <= last_point_i;
          root_q <= '0;
          sq_q <= '0;
          if (n_q >= NW'(MaxPoints)) state_q <= last_point_i ? StSetup : StIdle;
          else if (n_q == '0) state_q <= StWrite;
          else state_q <= StRdPrev;
        end
        StRdPrev: state_q <= StSqX;
        StSqX: begin sq_q <= 40'(mul_p); state_q <= StSqY; end
        StSqY: begin sq_q <= sq_q + 40'(mul_p); state_q <= StSqZ; end
        StSqZ: begin
          sq_q <= sq_q + 40'(mul_p);
          rad_q <= '0;
          it_q <= 5'd19;
          state_q <= StSqrt;
        end
        StSqrt: begin
          // bit-pair restoring square root, one result bit per cycle
          logic [41:0] rem;
          logic [41:0] tst;
          rem = {rad_q, sq_q[39:38]};
          tst = {19'd0, root_q, 2'b01};
          if (rem >= tst) begin
            rad_q  <= 40'(rem - tst);
            root_q <= {root_q[19:0], 1'b1};
          end else begin
            rad_q  <= rem[39:0];
            root_q <= {root_q[19:0], 1'b0};
          end
          sq_q <= {sq_q[37:0], 2'b00};
          it_q <= it_q - 5'd1;
          if (it_q == 5'd0) state_q <= StWrite;
        end
        StWrite: begin
          total_q <= (n_q == '0) ? '0 :
                     (cum_sum[LW] ? plars_pkg::LenMax : cum_sum[LW-1:0]);
          n_q <= n_q + NW'(1);
          state_q <= plast_q ? StSetup : StIdle;
        end
        StSetup: begin
          cnt_q <= cnt_clamp;
          si_q  <= '0;
          if (cnt_clamp == '0 || n_q < NW'(2)) state_q <= StEmpty;
          else state_q <= StS0Mul;
        end
        StS0Mul: begin s0_q <= LW'(mul_p[69:16]); state_q <= StSpan; end
        StSpan: begin span_q <= 64'(mul_p); state_q <= StStep; end
        StStep: begin
          if (cnt_q == KW'(1)) begin
            p_q <= s0_q; j_q <= '0; state_q <= StWalkRd;
          end else begin
            span_q <= 64'(mul_p); it_q <= '0; state_q <= StStepW;
          end
        end
        StStepW: begin
          it_q <= 5'd1;
          if (drsp.done) begin
            p_q <= LW'(s0_q + LW'(drsp.quo));
            j_q <= '0;
            state_q <= StWalkRd;
          end
        end
        StWalkRd: state_q <= StWalk;
        StWalk: begin
          if (32'(j_q) < 32'(n_q) - 2 && p_q > rd_c_q) begin
            j_q <= j_q + AddrW'(1);
            state_q <= StWalkRd;
          end else state_q <= StPtRd;
        end
        StPtRd: state_q <= StPtA;
        StPtA: begin
          a_q[0] <= rd_x_q; a_q[1] <= rd_y_q; a_q[2] <= rd_z_q;
          base_q <= rd_c_q;
          state_q <= StPtB;
        end
        StPtB: begin
          b_q[0] <= rd_x_q; b_q[1] <= rd_y_q; b_q[2] <= rd_z_q;
          den_q <= rd_c_q - base_q;
          num_q <= (p_q > base_q) ? ((p_q - base_q > rd_c_q - base_q) ?
                   rd_c_q - base_q : p_q - base_q) : '0;
          ax_q <= 2'd0;
          state_q <= StLerp;
        end
        StLerp: begin
          prod_q <= 48'(mul_p);
          neg_q <= mul_p[69];
          it_q <= '0;
          if (den_q == '0) begin
            res_q[ax_q] <= a_q[ax_q];
            if (ax_q == 2'd2) state_q <= StEmit;
            else ax_q <= ax_q + 2'd1;
          end else state_q <= StLerpW;
        end
        StLerpW: begin
          it_q <= 5'd1;
          if (drsp.done) begin
            res_q[ax_q] <= CW'(a_q[ax_q] + (neg_q ? CW'(-drsp.quo[CW-1:0]) :
                                                       drsp.quo[CW-1:0]));
            if (ax_q == 2'd2) state_q <= StEmit;
            else begin ax_q <= ax_q + 2'd1; state_q <= StLerp; end
          end
        end
        StEmit: if (out_load) begin
          ox_q <= res_q[0]; oy_q <= res_q[1]; oz_q <= res_q[2];
          olast_q <= (si_q == cnt_q - KW'(1));
          oempty_q <= 1'b0;
          ovalid_q <= 1'b1;
          if (si_q == cnt_q - KW'(1)) state_q <= StOut;
          else begin
            si_q <= si_q + KW'(1);
            state_q <= StSpan;
          end
        end
        StEmpty: if (out_load) begin
          ox_q <= '0; oy_q <= '0; oz_q <= '0;
          olast_q <= 1'b1; oempty_q <= 1'b1; ovalid_q <= 1'b1;
          state_q <= StOut;
        end
        StOut: begin
          n_q <= '0; total_q <= '0; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = ovalid_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign out_z_o       = oz_q;
  assign last_sample_o = olast_q;
  assign empty_res_o   = oempty_q;

  // the sequencer never takes a point while a curve is being sampled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit || state_q == StWalk) |-> !in_ready_o)
    else $error("point request taken during sampling");
  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_x_o)))
    else $error("held result changed");
  // store fill count is cleared once a curve has been emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |=> (n_q == '0))
    else $error("fill count not cleared");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for polyline_arc_length_resampler_core. Polylines are
// loaded point by point over a valid/ready request channel. A built-in
// predictor mirrors the point store and the arc-length resampling, queues
// the expected samples, and each sample that the block delivers is compared
// field by field. Directed curves cover the register extremes and the corner
// cases. Random curves follow under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CW          = plars_pkg::CoordW;
  localparam int unsigned FW          = plars_pkg::FracW;
  localparam int unsigned StorePoints = 256;
  localparam int unsigned SampleCap   = 64;
  localparam int unsigned CycleLimit  = 20000000;
  localparam int unsigned SettleCycles = 300;
  localparam logic [1:0]  RegUnused   = 2'd3;  // no register at this index

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 last;
    logic                 empty;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CW-1:0] out_x_o, out_y_o, out_z_o;
  logic last_sample_o, empty_res_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [FW-1:0] cfg_data_i = '0;

  // predictor state
  logic signed [CW-1:0] store_x [StorePoints];
  logic signed [CW-1:0] store_y [StorePoints];
  logic signed [CW-1:0] store_z [StorePoints];
  longint unsigned      store_cum [StorePoints];
  int unsigned          n_loaded;
  longint unsigned      run_length;
  longint unsigned      cfg_count, cfg_start, cfg_end;

  sample_t      pending_samples[$];
  int unsigned  errors;
  int unsigned  cycles;
  int unsigned  sent_points;
  int unsigned  send_idle_pct;   // chance in a hundred of a gap before a request
  int unsigned  recv_stall_pct;  // chance in a hundred of holding off a sample

  polyline_arc_length_resampler_core DUT (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // sample checker: the oldest expected sample must match
  always @(posedge clk_i) begin
    sample_t exp_s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("sample with none expected");
      end else begin
        exp_s = pending_samples.pop_front();
        if (out_x_o !== exp_s.x)
          report_mismatch($sformatf("out_x %0d, want %0d", out_x_o, exp_s.x));
        if (out_y_o !== exp_s.y)
          report_mismatch($sformatf("out_y %0d, want %0d", out_y_o, exp_s.y));
        if (out_z_o !== exp_s.z)
          report_mismatch($sformatf("out_z %0d, want %0d", out_z_o, exp_s.z));
        if (last_sample_o !== exp_s.last)
          report_mismatch($sformatf("last_sample %0b, want %0b",
                                    last_sample_o, exp_s.last));
        if (empty_res_o !== exp_s.empty)
          report_mismatch($sformatf("empty_res %0b, want %0b",
                                    empty_res_o, exp_s.empty));
      end
    end
  end

  function automatic longint unsigned bit_pair_sqrt(input longint unsigned v);
    longint unsigned root, probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [CW-1:0] interp(input longint a, input longint b,
                                                   input longint num, input longint den);
    longint r;
    if (den == 0) return a[CW-1:0];
    r = a + ((b - a) * num) / den;
    return r[CW-1:0];
  endfunction

  // mirror of the block: store the point, and on the last point queue samples
  function automatic void add_point(input logic signed [CW-1:0] x, y, z,
                                    input logic last);
    longint dx, dy, dz;
    longint unsigned acc, cnt, rs, re, tmp, s0, span, p, base, den, num;
    int unsigned npts, j;
    sample_t s;
    if (n_loaded < StorePoints) begin
      acc = 0;
      if (n_loaded > 0) begin
        dx = longint'(x) - longint'(store_x[n_loaded-1]);
        dy = longint'(y) - longint'(store_y[n_loaded-1]);
        dz = longint'(z) - longint'(store_z[n_loaded-1]);
        acc = store_cum[n_loaded-1] + bit_pair_sqrt(dx*dx + dy*dy + dz*dz);
        if (acc > plars_pkg::LenMax) acc = plars_pkg::LenMax;
      end
      store_x[n_loaded] = x;
      store_y[n_loaded] = y;
      store_z[n_loaded] = z;
      store_cum[n_loaded] = acc;
      run_length = acc;
      n_loaded++;
    end
    if (!last) return;
    npts = n_loaded;
    n_loaded = 0;
    cnt = (cfg_count > SampleCap) ? SampleCap : cfg_count;
    if (cnt == 0 || npts < 2) begin
      s = '{x: '0, y: '0, z: '0, last: 1'b1, empty: 1'b1};
      pending_samples.push_back(s);
      run_length = 0;
      return;
    end
    rs = (cfg_start > plars_pkg::FracOne) ? plars_pkg::FracOne : cfg_start;
    re = (cfg_end > plars_pkg::FracOne) ? plars_pkg::FracOne : cfg_end;
    if (rs > re) begin
      tmp = rs; rs = re; re = tmp;
    end
    s0 = (rs * run_length) >> 16;
    span = (re - rs) * run_length;
    run_length = 0;
    for (longint unsigned i = 0; i < cnt; i++) begin
      p = s0;
      if (cnt > 1) p += (span * i) / (64'd65536 * (cnt - 1));
      j = 0;
      while (j < npts - 2 && p > store_cum[j+1]) j++;
      base = store_cum[j];
      den = store_cum[j+1] - base;
      num = (p > base) ? p - base : 0;
      if (num > den) num = den;
      s.x = interp(store_x[j], store_x[j+1], num, den);
      s.y = interp(store_y[j], store_y[j+1], num, den);
      s.z = interp(store_z[j], store_z[j+1], num, den);
      s.last = (i == cnt - 1);
      s.empty = 1'b0;
      pending_samples.push_back(s);
    end
  endfunction

  // one point request; valid holds until the block takes it
  task automatic send_point(input logic signed [CW-1:0] x, y, z, input logic last);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pos_x_i = x;
    pos_y_i = y;
    pos_z_i = z;
    last_point_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    add_point(x, y, z, last);
    sent_points++;
  endtask

  // registers only change once every sample of the last curve is out
  task automatic write_reg(input logic [1:0] idx, input logic [FW-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_samples.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      plars_pkg::RegCount: cfg_count = data & 17'h7F;
      plars_pkg::RegStart: cfg_start = data;
      plars_pkg::RegEnd:   cfg_end = data;
      default: ;
    endcase
  endtask

  function automatic logic signed [CW-1:0] rand_coord(input bit wide);
    if (wide) return CW'($urandom);
    return CW'($signed($urandom_range(0, 4095)) - 2048);
  endfunction

  // reset values: five samples across the whole curve
  task automatic test_reset_config();
    send_point('0, '0, '0, 1'b0);
    send_point(18'sd2560, '0, '0, 1'b0);
    send_point(18'sd2560, 18'sd2560, 18'sd256, 1'b1);
  endtask

  // single point, zero count, out-of-range index, count above the cap
  task automatic test_degenerate();
    send_point(18'sd100, -18'sd100, 18'sd7, 1'b1);
    write_reg(plars_pkg::RegCount, 17'd0);
    send_point('0, '0, '0, 1'b0);
    send_point(18'sd512, '0, '0, 1'b1);
    write_reg(RegUnused, 17'h1FFFF);
    send_point(18'sd1, 18'sd1, 18'sd1, 1'b0);
    send_point(18'sd1, 18'sd1, 18'sd1, 1'b1);
    write_reg(plars_pkg::RegCount, 17'h7F);
    send_point(-18'sd300, 18'sd40, '0, 1'b0);
    send_point(18'sd300, -18'sd40, 18'sd900, 1'b1);
  endtask

  // fraction clamps and swap, count of one, zero-length segment, extremes
  task automatic test_ranges();
    write_reg(plars_pkg::RegCount, 17'd7);
    write_reg(plars_pkg::RegStart, 17'h1FFFF);
    write_reg(plars_pkg::RegEnd, 17'd16384);
    send_point(18'h20000, 18'h20000, 18'h20000, 1'b0);
    send_point(18'h20000, 18'h20000, 18'h20000, 1'b0);
    send_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 1'b0);
    send_point(18'h20000, 18'h1FFFF, 18'h20000, 1'b1);
    write_reg(plars_pkg::RegCount, 17'd1);
    write_reg(plars_pkg::RegStart, 17'd40000);
    write_reg(plars_pkg::RegEnd, 17'd40000);
    send_point(-18'sd1000, 18'sd5, 18'sd3000, 1'b0);
    send_point(18'sd1000, -18'sd5, -18'sd3000, 1'b1);
    write_reg(plars_pkg::RegCount, 17'd4);
    write_reg(plars_pkg::RegStart, 17'd0);
    write_reg(plars_pkg::RegEnd, 17'h1FFFF);
    send_point('0, '0, '0, 1'b0);
    send_point('0, '0, '0, 1'b1);
  endtask

  // random curves; mostly well formed, short and with few samples
  task automatic test_random_curves(input int unsigned target);
    int unsigned n_pts;
    bit wide;
    while (sent_points < target) begin
      if ($urandom_range(3) == 0) begin
        write_reg(plars_pkg::RegCount,
                  ($urandom_range(9) == 0) ? FW'($urandom_range(0, 127))
                                           : FW'($urandom_range(1, 8)));
        write_reg(plars_pkg::RegStart,
                  ($urandom_range(5) == 0) ? FW'($urandom_range(0, 131071))
                                           : FW'($urandom_range(0, 65536)));
        write_reg(plars_pkg::RegEnd,
                  ($urandom_range(5) == 0) ? FW'($urandom_range(0, 131071))
                                           : FW'($urandom_range(0, 65536)));
      end
      n_pts = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
      wide = $urandom_range(2) == 0;
      for (int i = 0; i < n_pts; i++)
        send_point(rand_coord(wide), rand_coord(wide), rand_coord(wide), i == n_pts - 1);
    end
  endtask

  initial begin
    cfg_count = 5;
    cfg_start = 0;
    cfg_end = plars_pkg::FracOne;
    n_loaded = 0;
    run_length = 0;
    errors = 0;
    sent_points = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_config();
    test_degenerate();
    test_ranges();
    // idle mixes: none, sender gaps, receiver stalls, light on both
    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random_curves(60);
    send_idle_pct = 67; recv_stall_pct = 0;
    test_random_curves(110);
    send_idle_pct = 0;  recv_stall_pct = 67;
    test_random_curves(160);
    send_idle_pct = 8;  recv_stall_pct = 8;
    test_random_curves(210);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_samples.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
